// ----- rtl/core/otq_pkg.sv -----
// Shared types and codes for the ordered timer queue.
package otq_pkg;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_CANCEL = 2'd1,
    OP_CHECK  = 2'd2,
    OP_NOP    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_NOTFOUND = 2'd2
  } status_t;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b00_0000_0001,
    S_MARK  = 10'b00_0000_0010,
    S_PICK  = 10'b00_0000_0100,
    S_FIRE  = 10'b00_0000_1000,
    S_SCAN  = 10'b00_0001_0000,
    S_ADD   = 10'b00_0010_0000,
    S_CRD   = 10'b00_0100_0000,
    S_CCHK  = 10'b00_1000_0000,
    S_LOAD  = 10'b01_0000_0000,
    S_OUT   = 10'b10_0000_0000
  } state_t;

endpackage

// ----- rtl/core/ordered_timer_queue.sv -----
// Deadline timer queue with add, cancel and expiry check over a slot table.
//
// Channel   Signals                                     Direction
// input     in_valid, in_ready, operation .. current_time   into block
// result    out_valid, out_ready, status .. last            out of block
//
// One transaction at a time; in_ready is high only while the block is idle.
// Every slot scan walks all TIMER_SLOTS entries through one registered memory
// read port and one shared 64-bit comparator. An add scans for a free slot and
// the earliest deadline, then writes; a cancel reads and checks its slot, then
// scans; a check marks due timers in one scan, then picks and fires them one at
// a time, earliest first, and ends with a scan for the next deadline.
// Reset clears the armed bits, the sequence counter and the sequencer; the
// timer memories are written before they are read. A stalled result holds.
module ordered_timer_queue
  import otq_pkg::*;
#(
  parameter int TIMER_SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  operation,
  input  logic [63:0] deadline_time,
  input  logic [31:0] repeat_interval,
  input  logic [3:0]  cancel_slot,
  input  logic [7:0]  cancel_tag,
  input  logic [63:0] current_time,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [3:0]  handle_slot,
  output logic [7:0]  handle_tag,
  output logic        fired,
  output logic        earliest_changed,
  output logic [63:0] next_deadline,
  output logic        deadline_valid,
  output logic        last
);

  localparam int SW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam int CW = $clog2(TIMER_SLOTS + 1);
  localparam logic [CW-1:0] N_C = CW'(TIMER_SLOTS);

  state_t state;

  logic [63:0] mem_dl  [TIMER_SLOTS];
  logic [31:0] mem_per [TIMER_SLOTS];
  logic [7:0]  mem_seq [TIMER_SLOTS];
  logic [SW-1:0] ord_slot [TIMER_SLOTS];
  logic [7:0]    ord_tag  [TIMER_SLOTS];

  logic [TIMER_SLOTS-1:0] armed;
  logic [TIMER_SLOTS-1:0] due;
  logic [7:0] seqc;

  op_t         op_r;
  logic [63:0] when_r;
  logic [31:0] per_r;
  logic [3:0]  cslot_r;
  logic [7:0]  ctag_r;
  logic [63:0] now_r;

  logic [CW-1:0] idx;
  logic          rd_v;
  logic [SW-1:0] rd_idx;
  logic [SW-1:0] rd_addr;
  logic [63:0]   rd_dl;
  logic [31:0]   rd_per;
  logic [7:0]    rd_seq;

  logic          best_v;
  logic [63:0]   best_dl;
  logic [SW-1:0] best_slot;
  logic [31:0]   best_per;
  logic [7:0]    best_seq;
  logic          free_v;
  logic [SW-1:0] free_slot;

  logic [CW-1:0] fire_n;
  logic [CW-1:0] out_cnt;
  logic          fired_r;
  status_t       status_r;
  logic [3:0]    res_slot;
  logic [7:0]    res_tag;
  logic          changed_r;
  logic [63:0]   nd_r;
  logic          ndv_r;
  logic [SW-1:0] ord_rd_slot;
  logic [7:0]    ord_rd_tag;

  logic [63:0] cmp_a;
  logic [63:0] cmp_b;
  logic        lt;
  logic [64:0] rearm_sum;
  logic [63:0] rearm_dl;
  logic        scan_issue;
  logic        scan_done;
  logic        cand;
  logic [SW-1:0] caddr;
  logic        c_hit;
  logic        mem_dl_we;
  logic        mem_all_we;
  logic [SW-1:0] wr_addr;
  logic [63:0] wr_dl;

  assign caddr      = SW'(cslot_r);
  assign scan_issue = idx < N_C;
  assign scan_done  = !scan_issue && !rd_v;
  assign rd_addr    = (state == S_CRD) ? caddr : (scan_issue ? idx[SW-1:0] : '0);

  always_comb begin
    case (state)
      S_MARK: begin
        cmp_a = now_r;
        cmp_b = rd_dl;
      end
      S_ADD: begin
        cmp_a = when_r;
        cmp_b = best_dl;
      end
      default: begin
        cmp_a = rd_dl;
        cmp_b = best_dl;
      end
    endcase
  end

  assign lt = cmp_a < cmp_b;

  assign rearm_sum = {1'b0, now_r} + {33'b0, best_per};
  assign rearm_dl  = rearm_sum[64] ? '1 : rearm_sum[63:0];

  assign cand = rd_v && ((state == S_PICK) ? due[rd_idx] : armed[rd_idx]) && (!best_v || lt);
  assign c_hit = (int'(cslot_r) < TIMER_SLOTS) && armed[caddr] && (rd_seq == ctag_r);

  assign mem_all_we = (state == S_ADD) && free_v;
  assign mem_dl_we  = mem_all_we || ((state == S_FIRE) && (best_per != '0));
  assign wr_addr    = (state == S_ADD) ? free_slot : best_slot;
  assign wr_dl      = (state == S_ADD) ? when_r : rearm_dl;

  always_ff @(posedge clk) begin
    if (mem_dl_we) begin
      mem_dl[wr_addr] <= wr_dl;
    end
    if (mem_all_we) begin
      mem_per[wr_addr] <= per_r;
      mem_seq[wr_addr] <= seqc;
    end
    rd_dl  <= mem_dl[rd_addr];
    rd_per <= mem_per[rd_addr];
    rd_seq <= mem_seq[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (state == S_FIRE) begin
      ord_slot[fire_n[SW-1:0]] <= best_slot;
      ord_tag[fire_n[SW-1:0]]  <= best_seq;
    end
    if (state == S_LOAD) begin
      ord_rd_slot <= ord_slot[out_cnt[SW-1:0]];
      ord_rd_tag  <= ord_tag[out_cnt[SW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      armed   <= '0;
      seqc    <= '0;
      rd_v    <= 1'b0;
      fire_n  <= '0;
      out_cnt <= '0;
      fired_r <= 1'b0;
    end else begin
      if (state == S_MARK || state == S_PICK || state == S_SCAN) begin
        if (scan_issue) begin
          idx    <= idx + CW'(1);
          rd_v   <= 1'b1;
          rd_idx <= idx[SW-1:0];
        end else begin
          rd_v <= 1'b0;
        end
      end
      if ((state == S_PICK || state == S_SCAN) && cand) begin
        best_v    <= 1'b1;
        best_dl   <= rd_dl;
        best_slot <= rd_idx;
        best_per  <= rd_per;
        best_seq  <= rd_seq;
      end

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            op_r      <= op_t'(operation);
            when_r    <= deadline_time;
            per_r     <= repeat_interval;
            cslot_r   <= cancel_slot;
            ctag_r    <= cancel_tag;
            now_r     <= current_time;
            fire_n    <= '0;
            fired_r   <= 1'b0;
            status_r  <= ST_OK;
            res_slot  <= '0;
            res_tag   <= '0;
            changed_r <= 1'b0;
            due       <= '0;
            idx       <= '0;
            rd_v      <= 1'b0;
            best_v    <= 1'b0;
            free_v    <= 1'b0;
            case (op_t'(operation))
              OP_CANCEL: state <= S_CRD;
              OP_CHECK:  state <= S_MARK;
              default:   state <= S_SCAN;
            endcase
          end
        end
        S_MARK: begin
          if (rd_v) begin
            due[rd_idx] <= armed[rd_idx] && !lt;
          end
          if (scan_done) begin
            idx    <= '0;
            best_v <= 1'b0;
            state  <= S_PICK;
          end
        end
        S_PICK: begin
          if (scan_done) begin
            idx <= '0;
            if (best_v) begin
              state <= S_FIRE;
            end else begin
              fired_r <= fire_n != '0;
              best_v  <= 1'b0;
              free_v  <= 1'b0;
              state   <= S_SCAN;
            end
          end
        end
        S_FIRE: begin
          due[best_slot] <= 1'b0;
          fire_n         <= fire_n + CW'(1);
          if (best_per == '0) begin
            armed[best_slot] <= 1'b0;
          end
          idx    <= '0;
          best_v <= 1'b0;
          state  <= S_PICK;
        end
        S_SCAN: begin
          if (rd_v && !armed[rd_idx] && !free_v) begin
            free_v    <= 1'b1;
            free_slot <= rd_idx;
          end
          if (scan_done) begin
            out_cnt <= '0;
            if (op_r == OP_ADD) begin
              state <= S_ADD;
            end else begin
              nd_r  <= best_v ? best_dl : '0;
              ndv_r <= best_v;
              state <= fired_r ? S_LOAD : S_OUT;
            end
          end
        end
        S_ADD: begin
          if (free_v) begin
            armed[free_slot] <= 1'b1;
            seqc             <= seqc + 8'd1;
            status_r         <= ST_OK;
            res_slot         <= 4'(free_slot);
            res_tag          <= seqc;
            changed_r        <= !best_v || lt;
            nd_r             <= (!best_v || lt) ? when_r : best_dl;
            ndv_r            <= 1'b1;
          end else begin
            status_r <= ST_FULL;
            nd_r     <= best_v ? best_dl : '0;
            ndv_r    <= best_v;
          end
          state <= S_OUT;
        end
        S_CRD: begin
          state <= S_CCHK;
        end
        S_CCHK: begin
          if (c_hit) begin
            armed[caddr] <= 1'b0;
          end
          status_r <= c_hit ? ST_OK : ST_NOTFOUND;
          res_slot <= cslot_r;
          res_tag  <= ctag_r;
          idx      <= '0;
          best_v   <= 1'b0;
          free_v   <= 1'b0;
          state    <= S_SCAN;
        end
        S_LOAD: begin
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_ready) begin
            if (last) begin
              state <= S_IDLE;
            end else begin
              out_cnt <= out_cnt + CW'(1);
              state   <= S_LOAD;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready         = state == S_IDLE;
  assign out_valid        = state == S_OUT;
  assign status           = status_r;
  assign handle_slot      = fired_r ? 4'(ord_rd_slot) : res_slot;
  assign handle_tag       = fired_r ? ord_rd_tag : res_tag;
  assign fired            = fired_r;
  assign earliest_changed = changed_r;
  assign next_deadline    = nd_r;
  assign deadline_valid   = ndv_r;
  assign last             = !fired_r || (out_cnt == fire_n - CW'(1));

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("Input and result handshakes overlap.");

  a_fire_count: assert property (@(posedge clk) disable iff (rst)
    fire_n <= N_C)
    else $error("More timers fired than the table holds.");

  a_fired_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && fired |-> status == ST_OK && !earliest_changed)
    else $error("A fired result carries a bad status or change flag.");

  a_changed_next: assert property (@(posedge clk) disable iff (rst)
    out_valid && earliest_changed |-> deadline_valid && next_deadline == when_r)
    else $error("A new earliest timer is not the reported next deadline.");

endmodule
